/* src/ihex_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and codes for the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_COLON = 3'd1;
  localparam logic [2:0] ERR_DIGIT    = 3'd2;
  localparam logic [2:0] ERR_TYPE     = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;

  // Record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  // Characters of interest
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [23:0] IMAGE_MAX = 24'hFF_FFFF;

  // One classified character, moved from the front end to the back end
  typedef struct packed {
    logic       eos;
    logic       is_colon;
    logic       is_newline;
    logic       is_hex;
    logic [3:0] nibble;
  } token_t;

endpackage
`default_nettype wire

/* src/ihex_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_front
// Accepts characters and classifies them into tokens (colon, newline,
// hex digit with its value, end of stream), one per cycle while the queue accepts them, registered.
// ----------------------------------------------------------------------------
module ihex_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [7:0]           character_i,
  input  wire                  end_of_stream_i,
  output logic                 tok_valid_o,
  input  wire                  tok_ready_i,
  output ihex_pkg::token_t     tok_o
);
  import ihex_pkg::*;

  logic   tok_valid_q, tok_valid_d;
  token_t tok_q, tok_d;
  logic   in_fire;

  assign in_ready_o = !tok_valid_q || tok_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Classify the incoming character
  always_comb begin
    tok_d            = '0;
    tok_d.eos        = end_of_stream_i;
    tok_d.is_colon   = (character_i == CHAR_COLON);
    tok_d.is_newline = (character_i == CHAR_NEWLINE);
    if (character_i >= 8'h30 && character_i <= 8'h39) begin
      tok_d.is_hex = 1'b1;
      tok_d.nibble = character_i[3:0];
    end else if ((character_i >= 8'h61 && character_i <= 8'h66) ||
                 (character_i >= 8'h41 && character_i <= 8'h46)) begin
      tok_d.is_hex = 1'b1;
      tok_d.nibble = character_i[3:0] + 4'd9;
    end
  end

  // Hold the token until the queue takes it
  always_comb begin
    tok_valid_d = tok_valid_q;
    if (in_fire) begin
      tok_valid_d = 1'b1;
    end else if (tok_ready_i) begin
      tok_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule
`default_nettype wire

/* src/ihex_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_queue
// Two-entry token queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ihex_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  ihex_pkg::token_t     push_tok_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output ihex_pkg::token_t     pop_tok_o
);
  import ihex_pkg::*;

  token_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule
`default_nettype wire

/* src/ihex_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_back
// Record state machine: pairs nibbles into bytes, tracks record fields,
// merges blocks and drives the registered result port.
// ----------------------------------------------------------------------------
module ihex_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_wdata_i,
  input  wire                  tok_valid_i,
  output logic                 tok_ready_o,
  input  ihex_pkg::token_t     tok_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           data_byte_o,
  output logic [16:0]          byte_address_o,
  output logic [15:0]          block_index_o,
  output logic                 new_block_o,
  output logic [7:0]           record_length_o,
  output logic [2:0]           error_code_o,
  output logic [23:0]          byte_total_o
);
  import ihex_pkg::*;

  localparam logic [3:0] PH_COLON   = 4'd0;
  localparam logic [3:0] PH_COUNT   = 4'd1;
  localparam logic [3:0] PH_ADDR_HI = 4'd2;
  localparam logic [3:0] PH_ADDR_LO = 4'd3;
  localparam logic [3:0] PH_TYPE    = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_CSUM    = 4'd6;
  localparam logic [3:0] PH_SKIP    = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;
  localparam logic [3:0] PH_ERROR   = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  hnib_q, hnib_d;
  logic        pend_q, pend_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  rkind_q, rkind_d;
  logic [7:0]  sum_q, sum_d;
  logic        opens_q, opens_d;
  logic        exists_q, exists_d;
  logic [16:0] bend_q, bend_d;
  logic [15:0] bcount_q, bcount_d;
  logic [23:0] image_q, image_d;
  logic        verify_q;

  logic        out_valid_q, out_valid_d;
  logic        emit;
  logic [1:0]  kind_d;
  logic [7:0]  data_d;
  logic [16:0] baddr_d;
  logic [15:0] bidx_d;
  logic        newb_d;
  logic [7:0]  rlen_d;
  logic [2:0]  ecode_d;

  logic [1:0]  kind_q;
  logic [7:0]  data_q;
  logic [16:0] baddr_q;
  logic [15:0] bidx_q;
  logic        newb_q;
  logic [7:0]  rlen_q;
  logic [2:0]  ecode_q;
  logic [23:0] osize_q;

  logic        tok_fire;
  logic [7:0]  byte_val;
  logic [15:0] cur_idx;
  logic [24:0] image_sum;
  logic [7:0]  offset;

  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign tok_fire    = tok_valid_i && tok_ready_o;
  assign byte_val    = {hnib_q, tok_i.nibble};
  assign cur_idx     = opens_q ? bcount_q : (bcount_q - 16'd1);
  assign image_sum   = {1'b0, image_q} + {17'd0, count_q};
  assign offset      = count_q - left_q;

  // Step the record state for one token
  always_comb begin
    phase_d  = phase_q;
    hnib_d   = hnib_q;
    pend_d   = pend_q;
    count_d  = count_q;
    left_d   = left_q;
    addr_d   = addr_q;
    rkind_d  = rkind_q;
    sum_d    = sum_q;
    opens_d  = opens_q;
    exists_d = exists_q;
    bend_d   = bend_q;
    bcount_d = bcount_q;
    image_d  = image_q;
    emit     = 1'b0;
    kind_d   = KIND_DATA;
    data_d   = '0;
    baddr_d  = '0;
    bidx_d   = '0;
    newb_d   = 1'b0;
    rlen_d   = '0;
    ecode_d  = ERR_NONE;

    if (tok_fire && phase_q != PH_ERROR && phase_q != PH_DONE) begin
      if (tok_i.eos) begin
        emit    = 1'b1;
        kind_d  = KIND_ERROR;
        phase_d = PH_ERROR;
        ecode_d = (phase_q == PH_COLON || phase_q == PH_SKIP) ? ERR_NO_COLON : ERR_DIGIT;
      end else if (phase_q == PH_COLON) begin
        if (!tok_i.is_colon) begin
          emit    = 1'b1;
          kind_d  = KIND_ERROR;
          phase_d = PH_ERROR;
          ecode_d = ERR_NO_COLON;
        end else begin
          sum_d   = '0;
          pend_d  = 1'b0;
          hnib_d  = '0;
          phase_d = PH_COUNT;
        end
      end else if (phase_q == PH_SKIP) begin
        if (tok_i.is_newline) phase_d = PH_COLON;
      end else if (!tok_i.is_hex) begin
        emit    = 1'b1;
        kind_d  = KIND_ERROR;
        phase_d = PH_ERROR;
        ecode_d = ERR_DIGIT;
      end else if (!pend_q) begin
        hnib_d = tok_i.nibble;
        pend_d = 1'b1;
      end else begin
        // Complete a byte
        pend_d = 1'b0;
        sum_d  = sum_q + byte_val;
        unique case (phase_q)
          PH_COUNT: begin
            count_d = byte_val;
            phase_d = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            addr_d  = {byte_val, 8'd0};
            phase_d = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            addr_d  = {addr_q[15:8], byte_val};
            phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            rkind_d = byte_val;
            left_d  = count_q;
            opens_d = !(exists_q && bend_q == {1'b0, addr_q});
            phase_d = (count_q != 8'd0) ? PH_DATA : PH_CSUM;
          end
          PH_DATA: begin
            if (rkind_q == REC_DATA) begin
              emit    = 1'b1;
              kind_d  = KIND_DATA;
              data_d  = byte_val;
              baddr_d = {1'b0, addr_q} + {9'd0, offset};
              bidx_d  = cur_idx;
              newb_d  = opens_q;
            end
            left_d = left_q - 8'd1;
            if (left_q == 8'd1) phase_d = PH_CSUM;
          end
          PH_CSUM: begin
            emit = 1'b1;
            if (rkind_q > REC_EOF) begin
              kind_d  = KIND_ERROR;
              phase_d = PH_ERROR;
              ecode_d = ERR_TYPE;
            end else if (verify_q && sum_d != 8'd0) begin
              kind_d  = KIND_ERROR;
              phase_d = PH_ERROR;
              ecode_d = ERR_CHECKSUM;
            end else if (rkind_q == REC_EOF) begin
              kind_d  = KIND_EOF;
              phase_d = PH_DONE;
              rlen_d  = count_q;
            end else begin
              // Close the data record: extend or open a block
              if (opens_q) begin
                bcount_d = bcount_q + 16'd1;
                exists_d = 1'b1;
                bend_d   = {1'b0, addr_q} + {9'd0, count_q};
              end else begin
                bend_d   = bend_q + {9'd0, count_q};
              end
              image_d = image_sum[24] ? IMAGE_MAX : image_sum[23:0];
              kind_d  = KIND_RECORD;
              phase_d = PH_SKIP;
              baddr_d = {1'b0, addr_q};
              bidx_d  = cur_idx;
              newb_d  = opens_q;
              rlen_d  = count_q;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COLON;
      hnib_q      <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      left_q      <= '0;
      addr_q      <= '0;
      rkind_q     <= '0;
      sum_q       <= '0;
      opens_q     <= 1'b0;
      exists_q    <= 1'b0;
      bend_q      <= '0;
      bcount_q    <= '0;
      image_q     <= '0;
      verify_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hnib_q      <= hnib_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      left_q      <= left_d;
      addr_q      <= addr_d;
      rkind_q     <= rkind_d;
      sum_q       <= sum_d;
      opens_q     <= opens_d;
      exists_q    <= exists_d;
      bend_q      <= bend_d;
      bcount_q    <= bcount_d;
      image_q     <= image_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) verify_q <= cfg_wdata_i;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      baddr_q <= baddr_d;
      bidx_q  <= bidx_d;
      newb_q  <= newb_d;
      rlen_q  <= rlen_d;
      ecode_q <= ecode_d;
      osize_q <= image_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign byte_address_o  = baddr_q;
  assign block_index_o   = bidx_q;
  assign new_block_o     = newb_q;
  assign record_length_o = rlen_q;
  assign error_code_o    = ecode_q;
  assign byte_total_o    = osize_q;

endmodule
`default_nettype wire

/* src/intel_hex_record_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// Intel HEX text parser: emits data bytes, record summaries and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one character per transfer,
//   with end_of_stream_i marking that the text is exhausted.
//   Output channel (out_valid_o/out_ready_i) gives at most one result per
//   character: a data byte, a data record summary, the end-of-file record,
//   or an error. Errors and the end-of-file record are final until reset.
//   cfg_we_i/cfg_wdata_i write verify_checksum; write only while idle.
//   Throughput: one character per cycle while out_ready_i does not hold a
//   result; the back end updates the record state once per token.
//   A result passes the classify register (loaded at the transfer), the
//   token queue and the result register, in that order.
//   A stalled receiver holds the result register; the front end and the
//   two-entry queue keep filling until they are full, then in_ready_o drops.
//   Reset clears all record and block state, the queue and verify_checksum.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  character_i,
  input  wire         end_of_stream_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [16:0] byte_address_o,
  output logic [15:0] block_index_o,
  output logic        new_block_o,
  output logic [7:0]  record_length_o,
  output logic [2:0]  error_code_o,
  output logic [23:0] byte_total_o
);
  import ihex_pkg::*;

  logic   f_valid, f_ready;
  token_t f_tok;
  logic   q_valid, q_ready;
  token_t q_tok;

  // Classify characters
  ihex_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .end_of_stream_i (end_of_stream_i),
    .tok_valid_o     (f_valid),
    .tok_ready_i     (f_ready),
    .tok_o           (f_tok)
  );

  // Decouple front and back
  ihex_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_tok_i   (f_tok),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_tok_o    (q_tok)
  );

  // Run the record state machine
  ihex_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .tok_valid_i     (q_valid),
    .tok_ready_o     (q_ready),
    .tok_i           (q_tok),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_address_o  (byte_address_o),
    .block_index_o   (block_index_o),
    .new_block_o     (new_block_o),
    .record_length_o (record_length_o),
    .error_code_o    (error_code_o),
    .byte_total_o    (byte_total_o)
  );

endmodule
`default_nettype wire

/* src/ihex_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks for the Intel HEX record parser.
// ----------------------------------------------------------------------------
module ihex_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [1:0]  kind_o,
  input wire [7:0]  data_byte_o,
  input wire [7:0]  record_length_o,
  input wire [2:0]  error_code_o
);
  import ihex_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(data_byte_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // Error is final
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_ERROR |=> !out_valid_o)
    else $error("result after error");

  // End of file is final
  a_eof_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_EOF |=> !out_valid_o)
    else $error("result after end of file");

  // Error carries a code and no payload
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> error_code_o != ERR_NONE &&
      data_byte_o == 8'd0 && record_length_o == 8'd0)
    else $error("bad error fields");

  // Data byte carries no code and no length
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |-> error_code_o == ERR_NONE &&
      record_length_o == 8'd0)
    else $error("bad data fields");

endmodule

bind intel_hex_record_parser_unit ihex_checker u_ihex_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .data_byte_o     (data_byte_o),
  .record_length_o (record_length_o),
  .error_code_o    (error_code_o)
);
`default_nettype wire

/* sim/ihex_record_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihex_record_checker
// Watches the character and result channels of the HEX record parser, keeps
// its own copy of the parse state, predicts every result and compares it
// field by field with what the parser delivers.
// ----------------------------------------------------------------------------
module ihex_record_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  character_i,
  input  wire         end_of_stream_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [1:0]  kind_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [16:0] byte_address_i,
  input  wire  [15:0] block_index_i,
  input  wire         new_block_i,
  input  wire  [7:0]  record_length_i,
  input  wire  [2:0]  error_code_i,
  input  wire  [23:0] byte_total_i,
  output logic [31:0] fail_count_o,
  output logic [31:0] pending_o
);
  import ihex_pkg::*;

  typedef enum logic [3:0] {
    WAIT_COLON, GET_COUNT, GET_ADDR_HI, GET_ADDR_LO, GET_TYPE,
    GET_DATA, GET_CSUM, SKIP_LINE, AFTER_EOF, HALTED
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [16:0] byte_address;
    logic [15:0] block_index;
    logic        new_block;
    logic [7:0]  record_length;
    logic [2:0]  error_code;
    logic [23:0] byte_total;
  } parse_result_t;

  // Parser state as the predictor sees it
  parse_phase_e  phase_q;
  logic [3:0]    hi_nibble;
  logic          nibble_held;
  logic [7:0]    rec_count;
  logic [7:0]    bytes_remaining;
  logic [15:0]   rec_addr;
  logic [7:0]    rec_type;
  logic [7:0]    byte_sum;
  logic          rec_new_block;
  logic          have_block;
  logic [16:0]   last_block_end;
  logic [15:0]   blocks_seen;
  logic [23:0]   total_bytes;
  logic          csum_enable;

  parse_result_t awaited_q[$];
  logic [31:0]   mismatches;

  // Decode one character as a hex digit; bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 4'(ch - 8'h30)};
    if (ch >= 8'h61 && ch <= 8'h66) return {1'b1, 4'(ch - 8'h61 + 8'd10)};
    if (ch >= 8'h41 && ch <= 8'h46) return {1'b1, 4'(ch - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  // Advance the parse state by one character and form its result, if any
  task automatic parse_char(input logic [7:0] ch, input logic eos,
                            output bit produced, output parse_result_t res);
    logic [4:0]  dig;
    logic [7:0]  b;
    logic [7:0]  offs;
    logic [2:0]  err;
    logic [24:0] grown;
    produced = 1'b0;
    res = '0;
    res.byte_total = total_bytes;
    err = ERR_NONE;
    if (phase_q == AFTER_EOF || phase_q == HALTED) begin
      // final state: drop everything
    end else if (eos) begin
      err = (phase_q == WAIT_COLON || phase_q == SKIP_LINE) ? ERR_NO_COLON : ERR_DIGIT;
    end else if (phase_q == WAIT_COLON) begin
      if (ch != CHAR_COLON) begin
        err = ERR_NO_COLON;
      end else begin
        byte_sum = 8'd0;
        nibble_held = 1'b0;
        hi_nibble = 4'd0;
        phase_q = GET_COUNT;
      end
    end else if (phase_q == SKIP_LINE) begin
      if (ch == CHAR_NEWLINE) phase_q = WAIT_COLON;
    end else begin
      dig = hex_digit(ch);
      if (!dig[4]) begin
        err = ERR_DIGIT;
      end else if (!nibble_held) begin
        hi_nibble = dig[3:0];
        nibble_held = 1'b1;
      end else begin
        nibble_held = 1'b0;
        b = {hi_nibble, dig[3:0]};
        byte_sum = byte_sum + b;
        case (phase_q)
          GET_COUNT: begin
            rec_count = b;
            phase_q = GET_ADDR_HI;
          end
          GET_ADDR_HI: begin
            rec_addr = {b, 8'h00};
            phase_q = GET_ADDR_LO;
          end
          GET_ADDR_LO: begin
            rec_addr[7:0] = b;
            phase_q = GET_TYPE;
          end
          GET_TYPE: begin
            rec_type = b;
            bytes_remaining = rec_count;
            rec_new_block = !(have_block && last_block_end == {1'b0, rec_addr});
            phase_q = (rec_count != 8'd0) ? GET_DATA : GET_CSUM;
          end
          GET_DATA: begin
            // data bytes go out before the record is known to be good
            if (rec_type == REC_DATA) begin
              offs = rec_count - bytes_remaining;
              produced = 1'b1;
              res.kind = KIND_DATA;
              res.data_byte = b;
              res.byte_address = {1'b0, rec_addr} + {9'd0, offs};
              res.block_index = rec_new_block ? blocks_seen : blocks_seen - 16'd1;
              res.new_block = rec_new_block;
            end
            bytes_remaining = bytes_remaining - 8'd1;
            if (bytes_remaining == 8'd0) phase_q = GET_CSUM;
          end
          GET_CSUM: begin
            // type error takes precedence over checksum error
            if (rec_type > REC_EOF) begin
              err = ERR_TYPE;
            end else if (csum_enable && byte_sum != 8'd0) begin
              err = ERR_CHECKSUM;
            end else if (rec_type == REC_EOF) begin
              phase_q = AFTER_EOF;
              produced = 1'b1;
              res.kind = KIND_EOF;
              res.record_length = rec_count;
            end else begin
              res.block_index = rec_new_block ? blocks_seen : blocks_seen - 16'd1;
              if (rec_new_block) begin
                blocks_seen = blocks_seen + 16'd1;
                have_block = 1'b1;
                last_block_end = {1'b0, rec_addr} + {9'd0, rec_count};
              end else begin
                last_block_end = last_block_end + {9'd0, rec_count};
              end
              grown = {1'b0, total_bytes} + {17'd0, rec_count};
              total_bytes = grown[24] ? IMAGE_MAX : grown[23:0];
              phase_q = SKIP_LINE;
              produced = 1'b1;
              res.kind = KIND_RECORD;
              res.byte_address = {1'b0, rec_addr};
              res.new_block = rec_new_block;
              res.record_length = rec_count;
              res.byte_total = total_bytes;
            end
          end
          default: ;
        endcase
      end
    end
    // errors are final until reset
    if (err != ERR_NONE) begin
      phase_q = HALTED;
      produced = 1'b1;
      res = '0;
      res.kind = KIND_ERROR;
      res.error_code = err;
      res.byte_total = total_bytes;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
      mismatches = mismatches + 1;
    end
  endtask

  // Predict on every character transfer, compare on every result transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit            produced;
    parse_result_t predicted;
    parse_result_t oldest;
    if (!rst_ni) begin
      phase_q = WAIT_COLON;
      hi_nibble = 4'd0;
      nibble_held = 1'b0;
      rec_count = 8'd0;
      bytes_remaining = 8'd0;
      rec_addr = 16'd0;
      rec_type = 8'd0;
      byte_sum = 8'd0;
      rec_new_block = 1'b0;
      have_block = 1'b0;
      last_block_end = 17'd0;
      blocks_seen = 16'd0;
      total_bytes = 24'd0;
      csum_enable = 1'b0;
      awaited_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) csum_enable = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        parse_char(character_i, end_of_stream_i, produced, predicted);
        if (produced) awaited_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: result of kind %0d with none expected", $time, kind_i);
          mismatches = mismatches + 1;
        end else begin
          oldest = awaited_q.pop_front();
          check_field("kind", oldest.kind, kind_i);
          check_field("data_byte", oldest.data_byte, data_byte_i);
          check_field("byte_address", oldest.byte_address, byte_address_i);
          check_field("block_index", oldest.block_index, block_index_i);
          check_field("new_block", oldest.new_block, new_block_i);
          check_field("record_length", oldest.record_length, record_length_i);
          check_field("error_code", oldest.error_code, error_code_i);
          check_field("byte_total", oldest.byte_total, byte_total_i);
        end
      end
      pending_o <= awaited_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* sim/intel_hex_record_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit_tb
// Feeds the HEX record parser with generated record text: a few fixed
// records, then random data records with merging and split blocks under
// both checksum settings, then one randomly chosen final event (end-of-file
// record, an error of each sort, or end of stream). Sender bursts and
// receiver stalls vary throughout; a checker predicts and compares.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit_tb;
  import ihex_pkg::*;

  // Case styles for generated hex digits
  localparam int CASE_UPPER = 0;
  localparam int CASE_LOWER = 1;
  localparam int CASE_MIXED = 2;

  // Receiver stall patterns
  localparam int RX_OPEN = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;

  // Ways the stream can end
  localparam int END_EOF        = 0;
  localparam int END_NO_COLON   = 1;
  localparam int END_BAD_DIGIT  = 2;
  localparam int END_BAD_TYPE   = 3;
  localparam int END_CHECKSUM   = 4;
  localparam int END_EOS_LINE   = 5;
  localparam int END_EOS_RECORD = 6;
  localparam int END_EOS_SKIP   = 7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_i;
  logic        end_of_stream_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [16:0] byte_address_o;
  logic [15:0] block_index_o;
  logic        new_block_o;
  logic [7:0]  record_length_o;
  logic [2:0]  error_code_o;
  logic [23:0] byte_total_o;
  logic [31:0] fail_count;
  logic [31:0] pending_count;

  logic [7:0]  line_q[$];
  logic [7:0]  payload[0:255];
  int          hex_case;
  int          burst_left;
  int          sent_chars;
  logic [15:0] next_addr;
  logic        csum_on;

  intel_hex_record_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_address_o  (byte_address_o),
    .block_index_o   (block_index_o),
    .new_block_o     (new_block_o),
    .record_length_o (record_length_o),
    .error_code_o    (error_code_o),
    .byte_total_o    (byte_total_o)
  );

  ihex_record_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .character_i     (character_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_i          (kind_o),
    .data_byte_i     (data_byte_o),
    .byte_address_i  (byte_address_o),
    .block_index_i   (block_index_o),
    .new_block_i     (new_block_o),
    .record_length_i (record_length_o),
    .error_code_i    (error_code_o),
    .byte_total_i    (byte_total_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the parser hangs
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: randomly changing stall patterns, plus two long hold-offs so
  // the parser fills up and backs up the character side
  initial begin : receiver
    int mode;
    int span;
    int seen;
    int holds_done;
    out_ready_i = 1'b0;
    span = 0;
    seen = 0;
    holds_done = 0;
    mode = RX_OPEN;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) seen++;
      if ((holds_done == 0 && seen >= 30) || (holds_done == 1 && seen >= 400)) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(RX_OPEN, RX_SLOW);
          span = $urandom_range(8, 64);
        end
        span--;
        case (mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_COIN: out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one character and hold it until the transfer; bursts and gaps
  task automatic send_item(input logic [7:0] ch, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    character_i <= ch;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    sent_chars++;
  endtask

  task automatic send_prefix(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(line_q[i], 1'b0);
  endtask

  // Stop sending, wait out every awaited result and the parser's pipeline
  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_count != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_checksum_check(input logic on);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    csum_on = on;
  endtask

  task automatic put_hex(input logic [7:0] b);
    int k;
    logic [3:0] n;
    logic lower;
    for (k = 1; k >= 0; k--) begin
      n = b[k*4 +: 4];
      lower = (hex_case == CASE_LOWER) ||
              (hex_case == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (n < 4'd10) line_q.push_back(8'h30 + n);
      else line_q.push_back((lower ? 8'h61 : 8'h41) + n - 8'd10);
    end
  endtask

  // Random data bytes, with the extremes over-weighted
  task automatic fill_payload(input int count);
    int i;
    int r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 7);
      payload[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    end
  endtask

  // Build one record line from payload[] into line_q
  task automatic build_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic bad_sum,
                              input logic end_line);
    int i;
    logic [7:0] sum;
    logic [7:0] b;
    line_q.delete();
    line_q.push_back(CHAR_COLON);
    sum = count + addr[15:8] + addr[7:0] + rtype;
    put_hex(count);
    put_hex(addr[15:8]);
    put_hex(addr[7:0]);
    put_hex(rtype);
    for (i = 0; i < count; i++) begin
      sum = sum + payload[i];
      put_hex(payload[i]);
    end
    b = -sum;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    put_hex(b);
    if (end_line) begin
      // trailing junk, then the newline that ends the skip
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_NEWLINE) b = 8'h0D;
        line_q.push_back(b);
      end
      line_q.push_back(CHAR_NEWLINE);
    end
  endtask

  initial begin : stimulus
    int ph;
    int budget;
    int pick;
    int ending;
    int p;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  c;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    character_i = 8'h00;
    end_of_stream_i = 1'b0;
    burst_left = 0;
    sent_chars = 0;
    csum_on = 1'b0;
    hex_case = CASE_UPPER;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty record at the top address opens the first block
    build_record(8'h00, 16'hFFFF, REC_DATA, 1'b0, 1'b1);
    send_prefix(line_q.size());
    // lower-case record extends it past 16 bits of address
    hex_case = CASE_LOWER;
    payload[0] = 8'hFF;
    payload[1] = 8'hAB;
    payload[2] = 8'hCD;
    payload[3] = 8'hEF;
    build_record(8'h04, 16'hFFFF, REC_DATA, 1'b0, 1'b1);
    send_prefix(line_q.size());
    // bad checksum is ignored while checking is off; new block at zero
    hex_case = CASE_UPPER;
    payload[0] = 8'h00;
    build_record(8'h01, 16'h0000, REC_DATA, 1'b1, 1'b1);
    send_prefix(line_q.size());
    next_addr = 16'h0001;

    // Random data records, alternating the checksum setting per phase
    for (ph = 0; ph < 4; ph++) begin
      set_checksum_check(ph % 2 == 0);
      if (ph == 2) begin
        // largest record at the top address
        hex_case = CASE_MIXED;
        fill_payload(255);
        build_record(8'hFF, 16'hFFFF, REC_DATA, 1'b0, 1'b1);
        send_prefix(line_q.size());
        next_addr = 16'hFFFF + 16'd255;
      end
      budget = sent_chars + 150;
      while (sent_chars < budget) begin
        pick = $urandom_range(0, 3);
        count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 40))
                                            : 8'($urandom_range(0, 16));
        if (pick < 2) addr = next_addr;
        else if (pick == 2) addr = 16'($urandom);
        else addr = 16'hFFF0 | 16'($urandom_range(0, 15));
        hex_case = $urandom_range(CASE_UPPER, CASE_MIXED);
        fill_payload(count);
        build_record(count, addr, REC_DATA,
                     !csum_on && ($urandom_range(0, 3) == 0), 1'b1);
        send_prefix(line_q.size());
        next_addr = addr + count;
      end
    end

    // One final event; everything after it is ignored by the parser
    ending = $urandom_range(END_EOF, END_EOS_SKIP);
    count = 8'($urandom_range(0, 6));
    addr = 16'($urandom);
    hex_case = CASE_MIXED;
    fill_payload(count);
    case (ending)
      END_EOF: begin
        build_record(count, addr, REC_EOF, 1'b0, 1'b1);
        send_prefix(line_q.size());
      end
      END_NO_COLON: begin
        // an empty line now and then, otherwise any non-colon character
        if ($urandom_range(0, 2) == 0) begin
          c = CHAR_NEWLINE;
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
        end
        send_item(c, 1'b0);
      end
      END_BAD_DIGIT: begin
        build_record(count, addr, REC_DATA, 1'b0, 1'b0);
        p = $urandom_range(1, line_q.size() - 1);
        send_prefix(p);
        do c = 8'($urandom_range(0, 255));
        while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66));
        send_item(c, 1'b0);
      end
      END_BAD_TYPE: begin
        build_record(count, addr, 8'($urandom_range(2, 255)),
                     $urandom_range(0, 1) == 1, 1'b1);
        send_prefix(line_q.size());
      end
      END_CHECKSUM: begin
        if (!csum_on) set_checksum_check(1'b1);
        build_record(count, addr, REC_DATA, 1'b1, 1'b1);
        send_prefix(line_q.size());
      end
      END_EOS_LINE: begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_EOS_RECORD: begin
        build_record(count, addr, REC_DATA, 1'b0, 1'b0);
        send_prefix($urandom_range(1, line_q.size() - 1));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        // stream ends while the rest of the line is skipped
        build_record(count, addr, REC_DATA, 1'b0, 1'b0);
        send_prefix(line_q.size());
        repeat ($urandom_range(0, 3)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CHAR_NEWLINE) c = 8'h0D;
          send_item(c, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    repeat (3) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
